// ===== sv/tps_pkg.sv =====
// ----------------------------------------------------------------------------
// tps_pkg
// Shared types, constants and helper functions of the tracker pattern sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package tps_pkg;

    // sizes
    localparam int SONG_BYTES   = 16384;
    localparam int STACK_DEPTH  = 16;
    localparam int MAX_COMMANDS = 256;
    localparam int SONG_AW      = $clog2(SONG_BYTES);
    localparam int SP_W         = $clog2(STACK_DEPTH);
    localparam int STK_ENTRIES  = 3 * STACK_DEPTH;
    localparam int STK_AW       = $clog2(STK_ENTRIES);
    localparam int CNT_W        = $clog2(MAX_COMMANDS + 1);
    localparam int NUM_NOTES    = 84;
    localparam int NUM_REGS     = 14;

    // item modes
    localparam logic [1:0] MODE_LOAD    = 2'd0;
    localparam logic [1:0] MODE_RESTART = 2'd1;
    localparam logic [1:0] MODE_TICK    = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_SONG_BASE = 2'd0;
    localparam logic [1:0] CFG_START_A   = 2'd1;
    localparam logic [1:0] CFG_START_B   = 2'd2;
    localparam logic [1:0] CFG_START_C   = 2'd3;

    // pattern command bytes
    localparam logic [7:0] CMD_JMP   = 8'h80;
    localparam logic [7:0] CMD_CALL  = 8'h81;
    localparam logic [7:0] CMD_LOOP  = 8'h82;
    localparam logic [7:0] CMD_RET   = 8'h83;
    localparam logic [7:0] CMD_NOISE = 8'h84;
    localparam logic [7:0] CMD_MIX   = 8'h85;
    localparam logic [7:0] CMD_ORN   = 8'h86;
    localparam logic [7:0] CMD_SMP   = 8'h87;
    localparam logic [7:0] CMD_TRN   = 8'h88;
    localparam logic [7:0] CMD_POP   = 8'h89;
    localparam logic [7:0] CMD_KEEP  = 8'h8a;
    localparam logic [7:0] CMD_FREE  = 8'h8b;
    localparam logic [7:0] CMD_SKIP  = 8'h8c;
    localparam logic [7:0] CMD_NADD  = 8'h8d;
    localparam logic [7:0] CMD_TADD  = 8'h8e;
    localparam logic [7:0] CMD_PUSHT = 8'h8f;
    localparam logic [7:0] CMD_POPT  = 8'h90;
    localparam logic [7:0] NOTE_MAX  = 8'h54;

    // sample and ornament stream codes
    localparam logic [7:0] SMP_JMP     = 8'h80;
    localparam logic [7:0] SMP_AMP_LIM = 8'h1e;
    localparam logic [7:0] SMP_AMP_OFS = 8'h32;
    localparam logic [7:0] ORN_JMP     = 8'h80;
    localparam logic [7:0] ORN_NOTE_ON = 8'h82;
    localparam logic [7:0] ORN_NOTE_OF = 8'h83;
    localparam logic [7:0] ORN_MIXFLIP = 8'h84;
    localparam logic [7:0] MIX_FLIP    = 8'h09;
    localparam logic [7:0] NOISE_MASK  = 8'h1f;
    localparam logic [7:0] MIXER_RESET = 8'h08;

    // channel flag bits
    localparam int FL_KEEP = 0;
    localparam int FL_RUN  = 1;
    localparam int FL_NEW  = 2;
    localparam int FL_ORN  = 3;

    typedef struct packed {
        logic [1:0]  mode;
        logic [13:0] load_offset;
        logic [7:0]  load_byte;
    } item_t;

    typedef struct packed {
        logic [3:0] reg_index;
        logic [7:0] reg_value;
        logic       last;
        logic       overrun;
    } result_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_NW, ST_PF, ST_PV, ST_PB, ST_PUSHPA,
        ST_WLO, ST_WHI, ST_WDN, ST_LP1, ST_LP2, ST_LP3, ST_POP,
        ST_SST, ST_SD, ST_SF, ST_SV, ST_STK, ST_OC, ST_OF, ST_OV,
        ST_OUT, ST_EMIT
    } state_t;

    typedef enum logic [4:0] {
        PC_JMP, PC_CALL, PC_LOOP, PC_RET, PC_NOISE, PC_MIX, PC_ORN, PC_SMP,
        PC_TRN, PC_POP, PC_KEEP, PC_FREE, PC_SKIP, PC_NADD, PC_TADD,
        PC_PUSHT, PC_POPT, PC_NOTE, PC_NOP
    } pcls_t;

    typedef struct packed {
        state_t     op;
        logic [1:0] ch;
        logic       load;
        logic       restart;
        logic       tick;
        logic [3:0] emit_idx;
    } cmd_t;

    typedef struct packed {
        logic [7:0] rd_byte;
        pcls_t      v_cls;
        logic       n_max;
        logic       nw_one;
        logic       st_one;
        logic       lp_nz;
        logic       run;
        logic       orn_go;
    } status_t;

    localparam logic [11:0] PERIOD [NUM_NOTES] = '{
        12'hfbf, 12'hedc, 12'he07, 12'hd3d, 12'hc7f, 12'hbcc, 12'hb22, 12'ha82,
        12'h9eb, 12'h95d, 12'h8d6, 12'h857, 12'h7df, 12'h76e, 12'h703, 12'h69f,
        12'h640, 12'h5e6, 12'h591, 12'h541, 12'h4f6, 12'h4ae, 12'h46b, 12'h42c,
        12'h3f0, 12'h3b7, 12'h382, 12'h34f, 12'h320, 12'h2f3, 12'h2c8, 12'h2a1,
        12'h27b, 12'h257, 12'h236, 12'h216, 12'h1f8, 12'h1dc, 12'h1c1, 12'h1a8,
        12'h190, 12'h179, 12'h164, 12'h150, 12'h13d, 12'h12c, 12'h11b, 12'h10b,
        12'h0fc, 12'h0ee, 12'h0e0, 12'h0d4, 12'h0c8, 12'h0bd, 12'h0b2, 12'h0a8,
        12'h09f, 12'h096, 12'h08d, 12'h085, 12'h07e, 12'h077, 12'h070, 12'h06a,
        12'h064, 12'h05e, 12'h059, 12'h054, 12'h04f, 12'h04b, 12'h047, 12'h043,
        12'h03f, 12'h03b, 12'h038, 12'h035, 12'h032, 12'h02f, 12'h02d, 12'h02a,
        12'h028, 12'h025, 12'h023, 12'h021
    };

    // tone period of a note, zero outside the table
    function automatic logic [15:0] note_tone(input logic [7:0] n);
        logic [15:0] t;
        t = 16'd0;
        if (n >= 8'd1 && n <= 8'(NUM_NOTES))
            t = 16'(PERIOD[7'(n - 8'd1)]);
        return t;
    endfunction

    // pattern byte decode
    function automatic pcls_t pat_class(input logic [7:0] v);
        pcls_t c;
        unique case (v)
            CMD_JMP:   c = PC_JMP;
            CMD_CALL:  c = PC_CALL;
            CMD_LOOP:  c = PC_LOOP;
            CMD_RET:   c = PC_RET;
            CMD_NOISE: c = PC_NOISE;
            CMD_MIX:   c = PC_MIX;
            CMD_ORN:   c = PC_ORN;
            CMD_SMP:   c = PC_SMP;
            CMD_TRN:   c = PC_TRN;
            CMD_POP:   c = PC_POP;
            CMD_KEEP:  c = PC_KEEP;
            CMD_FREE:  c = PC_FREE;
            CMD_SKIP:  c = PC_SKIP;
            CMD_NADD:  c = PC_NADD;
            CMD_TADD:  c = PC_TADD;
            CMD_PUSHT: c = PC_PUSHT;
            CMD_POPT:  c = PC_POPT;
            default:   c = (v <= NOTE_MAX) ? PC_NOTE : PC_NOP;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== sv/tps_ram.sv =====
// ----------------------------------------------------------------------------
// tps_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module tps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

// ===== sv/tps_ctrl.sv =====
// ----------------------------------------------------------------------------
// tps_ctrl
// Sequencer of the tick walk: steps through pattern, sample and ornament
// streams of each channel and then the register output beats.
// ----------------------------------------------------------------------------
`default_nettype none

module tps_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [1:0]       mode,
    input  wire tps_pkg::status_t sts,
    output tps_pkg::cmd_t         cmd,
    output logic                  busy,
    output logic                  strobe
);

    import tps_pkg::*;

    state_t     state_reg, state_next;
    state_t     ret_reg, ret_next;
    logic [1:0] ch_reg, ch_next;
    logic [3:0] k_reg, k_next;
    logic       accept;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);
    assign strobe = (state_reg == ST_EMIT);

    // command to the datapath
    always_comb
    begin
        cmd.op       = state_reg;
        cmd.ch       = ch_reg;
        cmd.load     = accept && (mode == MODE_LOAD);
        cmd.restart  = accept && (mode == MODE_RESTART);
        cmd.tick     = accept && (mode == MODE_TICK);
        cmd.emit_idx = k_reg;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
            ch_reg    <= 2'd0;
            k_reg     <= 4'd0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            ch_reg    <= ch_next;
            k_reg     <= k_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        ch_next    = ch_reg;
        k_next     = k_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && mode == MODE_TICK)
                begin
                    state_next = ST_NW;
                    ch_next    = 2'd0;
                end
            end
            ST_NW:     state_next = sts.nw_one ? ST_PF : ST_SD;
            ST_PF:     state_next = sts.n_max ? ST_OUT : ST_PV;
            ST_PV:
            begin
                case (pat_class(sts.rd_byte))
                    PC_JMP, PC_CALL, PC_ORN, PC_SMP:
                    begin
                        state_next = ST_WLO;
                        ret_next   = ST_PF;
                    end
                    PC_LOOP, PC_NOISE, PC_MIX, PC_TRN, PC_NADD, PC_TADD, PC_NOTE:
                        state_next = ST_PB;
                    PC_RET:            state_next = ST_LP1;
                    PC_POP, PC_POPT:   state_next = ST_POP;
                    default:           state_next = ST_PF;
                endcase
            end
            ST_PB:
            begin
                case (sts.v_cls)
                    PC_LOOP: state_next = ST_PUSHPA;
                    PC_NOTE: state_next = sts.run ? ST_SD : ST_SST;
                    default: state_next = ST_PF;
                endcase
            end
            ST_PUSHPA: state_next = ST_PF;
            ST_WLO:    state_next = ST_WHI;
            ST_WHI:    state_next = ST_WDN;
            ST_WDN:    state_next = ret_reg;
            ST_LP1:    state_next = ST_LP2;
            ST_LP2:    state_next = sts.lp_nz ? ST_LP3 : ST_PF;
            ST_LP3:    state_next = ST_PF;
            ST_POP:    state_next = ST_PF;
            ST_SST:    state_next = ST_OUT;
            ST_SD:     state_next = sts.st_one ? ST_SF : ST_OC;
            ST_SF:     state_next = sts.n_max ? ST_OC : ST_SV;
            ST_SV:
            begin
                if (sts.rd_byte == SMP_JMP)
                begin
                    state_next = ST_WLO;
                    ret_next   = ST_SF;
                end
                else if (sts.rd_byte < SMP_AMP_LIM)
                    state_next = ST_STK;
                else
                    state_next = ST_OC;
            end
            ST_STK:    state_next = ST_OC;
            ST_OC:     state_next = sts.orn_go ? ST_OF : ST_OUT;
            ST_OF:     state_next = sts.n_max ? ST_OUT : ST_OV;
            ST_OV:
            begin
                case (sts.rd_byte)
                    ORN_JMP:
                    begin
                        state_next = ST_WLO;
                        ret_next   = ST_OF;
                    end
                    ORN_NOTE_ON, ORN_NOTE_OF, ORN_MIXFLIP: state_next = ST_OF;
                    default:                               state_next = ST_OUT;
                endcase
            end
            ST_OUT:
            begin
                if (ch_reg == 2'd2)
                begin
                    state_next = ST_EMIT;
                    k_next     = 4'd0;
                end
                else
                begin
                    state_next = ST_NW;
                    ch_next    = ch_reg + 2'd1;
                end
            end
            ST_EMIT:
            begin
                if (k_reg == 4'(NUM_REGS - 1))
                    state_next = ST_IDLE;
                else
                    k_next = k_reg + 4'd1;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/tps_dp.sv =====
// ----------------------------------------------------------------------------
// tps_dp
// Datapath: song memory, call stacks, configuration and channel state, and
// the register values put out at the end of a tick.
// ----------------------------------------------------------------------------
`default_nettype none

module tps_dp (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire tps_pkg::cmd_t    cmd,
    input  wire tps_pkg::item_t   item,
    input  wire logic             cfg_we,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [15:0]      cfg_data,
    output tps_pkg::status_t      sts,
    output tps_pkg::result_t      result
);

    import tps_pkg::*;

    // configuration
    logic [15:0] base_reg, start_a_reg, start_b_reg, start_c_reg;

    // channel state
    logic [15:0]     pa_reg     [3];
    logic [15:0]     opos_reg   [3];
    logic [15:0]     ostart_reg [3];
    logic [15:0]     spos_reg   [3];
    logic [15:0]     sstart_reg [3];
    logic [15:0]     nwait_reg  [3];
    logic [15:0]     tone_reg   [3];
    logic [7:0]      sticks_reg [3];
    logic [7:0]      mixer_reg  [3];
    logic [7:0]      note_reg   [3];
    logic [7:0]      transp_reg [3];
    logic [7:0]      amp_reg    [3];
    logic [3:0]      flags_reg  [3];
    logic [SP_W-1:0] sp_reg     [3];
    logic [7:0]      noise_reg;
    logic            ovr_reg;

    // walk temporaries
    logic [CNT_W-1:0] n_reg;
    logic [7:0]       lo_reg;
    logic [15:0]      wa_reg;
    state_t           wdst_reg;
    pcls_t            wcls_reg;

    // song memory
    logic [15:0]        rd_addr;
    logic [15:0]        rd_off;
    logic [SONG_AW-1:0] song_waddr;
    logic               song_we;
    logic [7:0]         song_q;
    logic               oor_reg;
    logic [7:0]         rbyte;

    // call stacks
    logic [STK_AW-1:0] stk_raddr, stk_waddr;
    logic [15:0]       stk_wdata, stk_q, stk_val;
    logic              stk_we;
    logic              stk_vld_reg [STK_ENTRIES];
    logic              stk_rv_reg;

    logic [1:0]      ch;
    logic [SP_W-1:0] sp_inc, sp_dec, sp_dec2;
    logic [15:0]     lp_cnt;
    logic [15:0]     word;
    logic [7:0]      nadd;
    logic [7:0]      orn_note;
    logic [9:0]      mix_all;
    logic [3:0]      rix;
    pcls_t           pv_cls;

    assign ch = cmd.ch;

    function automatic logic [STK_AW-1:0] stk_addr(input logic [1:0] c,
                                                   input logic [SP_W-1:0] i);
        return STK_AW'(c) * STK_AW'(STACK_DEPTH) + STK_AW'(i);
    endfunction

    // stack pointer neighbours with wrap
    always_comb
    begin
        sp_inc  = (sp_reg[ch] == SP_W'(STACK_DEPTH - 1)) ? '0 : sp_reg[ch] + 1'b1;
        sp_dec  = (sp_reg[ch] == '0) ? SP_W'(STACK_DEPTH - 1) : sp_reg[ch] - 1'b1;
        sp_dec2 = (sp_dec == '0) ? SP_W'(STACK_DEPTH - 1) : sp_dec - 1'b1;
    end

    assign rbyte   = oor_reg ? 8'd0 : song_q;
    assign stk_val = stk_rv_reg ? stk_q : 16'd0;
    assign lp_cnt  = stk_val - 16'd1;
    assign word    = {rbyte, lo_reg};
    assign pv_cls  = pat_class(rbyte);
    assign nadd    = (noise_reg + rbyte) & NOISE_MASK;
    assign orn_note = note_reg[ch] + rbyte;

    // song memory read address
    always_comb
    begin
        case (cmd.op)
            ST_PB:   rd_addr = sstart_reg[ch] + 16'd1;
            ST_WLO:  rd_addr = wa_reg;
            ST_WHI:  rd_addr = wa_reg + 16'd1;
            ST_SF:   rd_addr = spos_reg[ch];
            ST_SV:   rd_addr = spos_reg[ch];
            ST_OF:   rd_addr = opos_reg[ch];
            default: rd_addr = pa_reg[ch];
        endcase
    end

    assign rd_off     = rd_addr - base_reg;
    assign song_we    = cmd.load && (32'(item.load_offset) < SONG_BYTES);
    assign song_waddr = SONG_AW'(item.load_offset);

    tps_ram #(
        .WIDTH (8),
        .DEPTH (SONG_BYTES)
    ) u_song (
        .clk   (clk),
        .we    (song_we),
        .waddr (song_waddr),
        .wdata (item.load_byte),
        .raddr (SONG_AW'(rd_off)),
        .rdata (song_q)
    );

    // out of range reads answer zero
    always_ff @(posedge clk)
    begin
        oor_reg <= ({1'b0, rd_off} >= 17'(SONG_BYTES));
    end

    // call stack ports
    always_comb
    begin
        stk_we    = 1'b0;
        stk_waddr = stk_addr(ch, sp_reg[ch]);
        stk_wdata = pa_reg[ch];
        stk_raddr = stk_addr(ch, sp_dec);
        case (cmd.op)
            ST_PV:
            begin
                if (pv_cls == PC_CALL)
                begin
                    stk_we    = 1'b1;
                    stk_wdata = pa_reg[ch] + 16'd2;
                end
                else if (pv_cls == PC_PUSHT)
                begin
                    stk_we    = 1'b1;
                    stk_wdata = {8'd0, transp_reg[ch]};
                end
            end
            ST_PB:
            begin
                if (wcls_reg == PC_LOOP)
                begin
                    stk_we    = 1'b1;
                    stk_wdata = {8'd0, rbyte};
                end
            end
            ST_PUSHPA: stk_we = 1'b1;
            ST_LP1:    stk_raddr = stk_addr(ch, sp_dec2);
            ST_LP2:
            begin
                stk_we    = 1'b1;
                stk_waddr = stk_addr(ch, sp_dec2);
                stk_wdata = lp_cnt;
            end
            default:   stk_we = 1'b0;
        endcase
    end

    tps_ram #(
        .WIDTH (16),
        .DEPTH (STK_ENTRIES)
    ) u_stack (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_q)
    );

    // stack entry valid bits, an unwritten entry reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stk_rv_reg <= 1'b0;
            for (int i = 0; i < STK_ENTRIES; i++)
                stk_vld_reg[i] <= 1'b0;
        end
        else
        begin
            stk_rv_reg <= stk_vld_reg[stk_raddr] && !cmd.restart;
            if (cmd.restart)
            begin
                for (int i = 0; i < STK_ENTRIES; i++)
                    stk_vld_reg[i] <= 1'b0;
            end
            else if (stk_we)
            begin
                stk_vld_reg[stk_waddr] <= 1'b1;
            end
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg    <= 16'd0;
            start_a_reg <= 16'd0;
            start_b_reg <= 16'd0;
            start_c_reg <= 16'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SONG_BASE: base_reg    <= cfg_data;
                CFG_START_A:   start_a_reg <= cfg_data;
                CFG_START_B:   start_b_reg <= cfg_data;
                CFG_START_C:   start_c_reg <= cfg_data;
                default:       base_reg    <= base_reg;
            endcase
        end
    end

    // channel state and walk
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < 3; c++)
            begin
                pa_reg[c]     <= 16'd0;
                opos_reg[c]   <= 16'd0;
                ostart_reg[c] <= 16'd0;
                spos_reg[c]   <= 16'd0;
                sstart_reg[c] <= 16'd0;
                nwait_reg[c]  <= 16'd1;
                tone_reg[c]   <= 16'd0;
                sticks_reg[c] <= 8'd0;
                mixer_reg[c]  <= MIXER_RESET;
                note_reg[c]   <= 8'd0;
                transp_reg[c] <= 8'd0;
                amp_reg[c]    <= 8'd0;
                flags_reg[c]  <= 4'd0;
                sp_reg[c]     <= '0;
            end
            noise_reg <= 8'd0;
            ovr_reg   <= 1'b0;
            n_reg     <= '0;
            lo_reg    <= 8'd0;
            wa_reg    <= 16'd0;
            wdst_reg  <= ST_PF;
            wcls_reg  <= PC_NOP;
        end
        else
        begin
            if (cmd.restart)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    opos_reg[c]   <= 16'd0;
                    ostart_reg[c] <= 16'd0;
                    spos_reg[c]   <= 16'd0;
                    sstart_reg[c] <= 16'd0;
                    nwait_reg[c]  <= 16'd1;
                    tone_reg[c]   <= 16'd0;
                    sticks_reg[c] <= 8'd0;
                    mixer_reg[c]  <= MIXER_RESET;
                    note_reg[c]   <= 8'd0;
                    transp_reg[c] <= 8'd0;
                    amp_reg[c]    <= 8'd0;
                    flags_reg[c]  <= 4'd0;
                    sp_reg[c]     <= '0;
                end
                pa_reg[0] <= start_a_reg;
                pa_reg[1] <= start_b_reg;
                pa_reg[2] <= start_c_reg;
                noise_reg <= 8'd0;
            end
            if (cmd.tick)
            begin
                ovr_reg <= 1'b0;
            end
            case (cmd.op)
                // note wait countdown
                ST_NW:
                begin
                    nwait_reg[ch] <= nwait_reg[ch] - 16'd1;
                    n_reg         <= '0;
                end
                // pattern byte fetch
                ST_PF:
                begin
                    if (sts.n_max)
                    begin
                        ovr_reg       <= 1'b1;
                        nwait_reg[ch] <= 16'd1;
                    end
                    else
                    begin
                        pa_reg[ch] <= pa_reg[ch] + 16'd1;
                        n_reg      <= n_reg + 1'b1;
                    end
                end
                // pattern byte decode
                ST_PV:
                begin
                    wcls_reg <= pv_cls;
                    wa_reg   <= pa_reg[ch];
                    wdst_reg <= ST_PF;
                    case (pv_cls)
                        PC_CALL:
                            sp_reg[ch] <= sp_inc;
                        PC_LOOP, PC_NOISE, PC_MIX, PC_TRN, PC_NADD, PC_TADD:
                            pa_reg[ch] <= pa_reg[ch] + 16'd1;
                        PC_ORN, PC_SMP, PC_SKIP:
                            pa_reg[ch] <= pa_reg[ch] + 16'd2;
                        PC_POP, PC_POPT:
                            sp_reg[ch] <= sp_dec;
                        PC_KEEP:
                        begin
                            flags_reg[ch][FL_KEEP] <= 1'b1;
                            flags_reg[ch][FL_RUN]  <= 1'b0;
                        end
                        PC_FREE:
                        begin
                            flags_reg[ch][FL_KEEP] <= 1'b0;
                            flags_reg[ch][FL_RUN]  <= 1'b0;
                        end
                        PC_PUSHT:
                            sp_reg[ch] <= sp_inc;
                        PC_NOTE:
                        begin
                            pa_reg[ch] <= pa_reg[ch] + 16'd1;
                            if (rbyte != 8'd0)
                            begin
                                note_reg[ch]          <= rbyte + transp_reg[ch];
                                tone_reg[ch]          <= note_tone(rbyte + transp_reg[ch]);
                                flags_reg[ch][FL_ORN] <= 1'b0;
                            end
                            else
                            begin
                                tone_reg[ch] <= 16'd0;
                            end
                        end
                        default: ;
                    endcase
                end
                // operand byte of a pattern command
                ST_PB:
                begin
                    case (wcls_reg)
                        PC_LOOP:  sp_reg[ch]     <= sp_inc;
                        PC_NOISE: noise_reg      <= rbyte;
                        PC_MIX:   mixer_reg[ch]  <= rbyte;
                        PC_TRN:   transp_reg[ch] <= rbyte;
                        PC_NADD:  noise_reg      <= nadd;
                        PC_TADD:  transp_reg[ch] <= transp_reg[ch] + rbyte;
                        PC_NOTE:
                        begin
                            nwait_reg[ch]         <= {8'd0, rbyte};
                            opos_reg[ch]          <= ostart_reg[ch];
                            flags_reg[ch][FL_NEW] <= 1'b1;
                            if (!flags_reg[ch][FL_RUN])
                            begin
                                flags_reg[ch][FL_RUN] <= flags_reg[ch][FL_KEEP];
                                spos_reg[ch]          <= sstart_reg[ch] + 16'd2;
                            end
                        end
                        default:  noise_reg <= noise_reg;
                    endcase
                end
                ST_PUSHPA:
                    sp_reg[ch] <= sp_inc;
                // two byte word read
                ST_WHI:
                    lo_reg <= rbyte;
                ST_WDN:
                begin
                    case (wdst_reg)
                        ST_SF: spos_reg[ch] <= word;
                        ST_OF: opos_reg[ch] <= word;
                        default:
                        begin
                            case (wcls_reg)
                                PC_ORN:  ostart_reg[ch] <= word;
                                PC_SMP:  sstart_reg[ch] <= word;
                                default: pa_reg[ch]     <= word;
                            endcase
                        end
                    endcase
                end
                // loop counter and repeat
                ST_LP2:
                begin
                    if (lp_cnt[7:0] == 8'd0)
                        sp_reg[ch] <= sp_dec2;
                end
                ST_LP3:
                    pa_reg[ch] <= stk_val;
                ST_POP:
                begin
                    if (wcls_reg == PC_POP)
                        pa_reg[ch] <= stk_val;
                    else
                        transp_reg[ch] <= stk_val[7:0];
                end
                ST_SST:
                    sticks_reg[ch] <= rbyte;
                // sample stream
                ST_SD:
                begin
                    sticks_reg[ch] <= sticks_reg[ch] - 8'd1;
                    n_reg          <= '0;
                end
                ST_SF:
                begin
                    if (sts.n_max)
                    begin
                        ovr_reg        <= 1'b1;
                        sticks_reg[ch] <= 8'd1;
                    end
                    else
                    begin
                        spos_reg[ch] <= spos_reg[ch] + 16'd1;
                        n_reg        <= n_reg + 1'b1;
                    end
                end
                ST_SV:
                begin
                    wdst_reg <= ST_SF;
                    if (rbyte == SMP_JMP)
                        wa_reg <= spos_reg[ch];
                    else if (rbyte < SMP_AMP_LIM)
                    begin
                        amp_reg[ch]  <= rbyte;
                        spos_reg[ch] <= spos_reg[ch] + 16'd1;
                    end
                    else
                    begin
                        amp_reg[ch]    <= rbyte - SMP_AMP_OFS;
                        sticks_reg[ch] <= 8'd1;
                    end
                end
                ST_STK:
                    sticks_reg[ch] <= rbyte;
                // ornament stream
                ST_OC:
                    n_reg <= '0;
                ST_OF:
                begin
                    if (sts.n_max)
                        ovr_reg <= 1'b1;
                    else
                    begin
                        opos_reg[ch] <= opos_reg[ch] + 16'd1;
                        n_reg        <= n_reg + 1'b1;
                    end
                end
                ST_OV:
                begin
                    wdst_reg <= ST_OF;
                    case (rbyte)
                        ORN_JMP:     wa_reg <= opos_reg[ch];
                        ORN_NOTE_ON: flags_reg[ch][FL_ORN] <= 1'b1;
                        ORN_NOTE_OF: flags_reg[ch][FL_ORN] <= 1'b0;
                        ORN_MIXFLIP: mixer_reg[ch] <= mixer_reg[ch] ^ MIX_FLIP;
                        default:
                        begin
                            if (!flags_reg[ch][FL_ORN])
                                tone_reg[ch] <= tone_reg[ch] + {{8{rbyte[7]}}, rbyte};
                            else
                            begin
                                note_reg[ch] <= orn_note;
                                tone_reg[ch] <= note_tone(orn_note);
                            end
                        end
                    endcase
                end
                // end of channel
                ST_OUT:
                    flags_reg[ch][FL_NEW] <= 1'b0;
                default:
                    n_reg <= n_reg;
            endcase
        end
    end

    // status to the sequencer
    always_comb
    begin
        sts.rd_byte = rbyte;
        sts.v_cls   = wcls_reg;
        sts.n_max   = (n_reg == CNT_W'(MAX_COMMANDS));
        sts.nw_one  = (nwait_reg[ch] == 16'd1);
        sts.st_one  = (sticks_reg[ch] == 8'd1);
        sts.lp_nz   = (lp_cnt[7:0] != 8'd0);
        sts.run     = flags_reg[ch][FL_RUN];
        sts.orn_go  = (tone_reg[ch] != 16'd0) && !flags_reg[ch][FL_NEW];
    end

    // sound register beats, highest register first
    assign rix     = 4'(NUM_REGS - 1) - cmd.emit_idx;
    assign mix_all = {mixer_reg[2], 2'b00} | {1'b0, mixer_reg[1], 1'b0}
                   | {2'b00, mixer_reg[0]};

    always_comb
    begin
        result.reg_index = rix;
        result.last      = (rix == 4'd0);
        result.overrun   = ovr_reg;
        case (rix)
            4'd0:    result.reg_value = tone_reg[0][7:0];
            4'd1:    result.reg_value = tone_reg[0][15:8];
            4'd2:    result.reg_value = tone_reg[1][7:0];
            4'd3:    result.reg_value = tone_reg[1][15:8];
            4'd4:    result.reg_value = tone_reg[2][7:0];
            4'd5:    result.reg_value = tone_reg[2][15:8];
            4'd6:    result.reg_value = noise_reg;
            4'd7:    result.reg_value = mix_all[7:0];
            4'd8:    result.reg_value = (tone_reg[0] != 16'd0) ? amp_reg[0] : 8'd0;
            4'd9:    result.reg_value = (tone_reg[1] != 16'd0) ? amp_reg[1] : 8'd0;
            4'd10:   result.reg_value = (tone_reg[2] != 16'd0) ? amp_reg[2] : 8'd0;
            default: result.reg_value = 8'd0;
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/tracker_pattern_sequencer.sv =====
// ----------------------------------------------------------------------------
// tracker_pattern_sequencer
// Three channel tracker pattern player that produces the 14 sound
// generator register writes of each tick.
// ----------------------------------------------------------------------------
// A load or restart item is taken while idle and does not raise busy. A tick
// item walks the song: every song byte is read through the registered song
// memory port, addressed in one state and used in the next, a two byte jump
// address adds the states WLO, WHI and WDN, a loop push adds PUSHPA and the
// end of a loop adds LP1, LP2 and, while the loop repeats, LP3, then 14
// output beats come, one per cycle, register 13 first and register 0 marked
// by last. Every channel walk is capped at 256 commands. busy is high from
// the accepted tick until its last beat. Each beat is on result for exactly
// one cycle, with result_valid high, and cannot be held off.
// ----------------------------------------------------------------------------
`default_nettype none

module tracker_pattern_sequencer (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire tps_pkg::item_t  item,
    input  wire logic            cfg_we,
    input  wire logic [1:0]      cfg_index,
    input  wire logic [15:0]     cfg_data,
    output logic                 result_valid,
    output tps_pkg::result_t     result
);

    import tps_pkg::*;

    cmd_t    cmd;
    status_t sts;

    // sequencer
    tps_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .mode   (item.mode),
        .sts    (sts),
        .cmd    (cmd),
        .busy   (busy),
        .strobe (result_valid)
    );

    // datapath
    tps_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sts       (sts),
        .result    (result)
    );

endmodule

`default_nettype wire

// ===== tb/register_write_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// register_write_checker
// Watches the item, configuration and result ports of the tracker pattern
// sequencer, keeps its own copy of the song memory and channel state, works
// out the 14 register writes of every accepted tick and compares each beat
// against the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module register_write_checker
    import tps_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    input  wire logic    busy,
    input  wire item_t   item,
    input  wire logic    cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic    result_valid,
    input  wire result_t result,
    output int           mismatches,
    output int           pending
);

    // song memory and configuration
    logic [7:0]  song_mem [SONG_BYTES];
    logic [15:0] song_base;
    logic [15:0] start_reg [3];

    // channel state
    logic [15:0] pat [3];
    logic [15:0] orn_pos [3];
    logic [15:0] orn_start [3];
    logic [15:0] smp_pos [3];
    logic [15:0] smp_start [3];
    logic [15:0] note_wait [3];
    logic [15:0] tone [3];
    logic [7:0]  smp_ticks [3];
    logic [7:0]  mixer [3];
    logic [7:0]  note_no [3];
    logic [7:0]  trans [3];
    logic [7:0]  amp [3];
    logic [3:0]  flags [3];
    logic [15:0] stack_mem [3][STACK_DEPTH];
    logic [SP_W-1:0] sp [3];
    logic [7:0]  noise;
    logic [7:0]  sound_regs [NUM_REGS];

    // register writes still to come, oldest first
    result_t reg_writes_due [$];

    function automatic logic [7:0] song_byte(input logic [15:0] a);
        logic [15:0] off;
        off = a - song_base;
        return (int'(off) < SONG_BYTES) ? song_mem[off[SONG_AW-1:0]] : 8'h00;
    endfunction

    function automatic logic [15:0] song_word(input logic [15:0] a);
        return {song_byte(a + 16'd1), song_byte(a)};
    endfunction

    function automatic logic [15:0] pitch(input logic [7:0] n);
        if (n >= 8'd1 && int'(n) <= NUM_NOTES)
            return {4'h0, PERIOD[int'(n) - 1]};
        return 16'h0000;
    endfunction

    function automatic void stack_push(input int c, input logic [15:0] v);
        stack_mem[c][sp[c]] = v;
        sp[c] = sp[c] + 1'b1;
    endfunction

    function automatic logic [15:0] stack_pop(input int c);
        sp[c] = sp[c] - 1'b1;
        return stack_mem[c][sp[c]];
    endfunction

    function automatic logic [7:0] next_pattern_byte(input int c);
        logic [15:0] a;
        a = pat[c];
        pat[c] = a + 16'd1;
        return song_byte(a);
    endfunction

    // channels back to their start addresses
    function automatic void rewind_channels();
        for (int c = 0; c < 3; c++) begin
            orn_pos[c]   = '0;
            orn_start[c] = '0;
            smp_pos[c]   = '0;
            smp_start[c] = '0;
            tone[c]      = '0;
            smp_ticks[c] = '0;
            note_no[c]   = '0;
            trans[c]     = '0;
            amp[c]       = '0;
            flags[c]     = '0;
            sp[c]        = '0;
            mixer[c]     = MIXER_RESET;
            note_wait[c] = 16'd1;
            pat[c]       = start_reg[c];
            for (int k = 0; k < STACK_DEPTH; k++)
                stack_mem[c][k] = '0;
        end
        for (int r = 0; r < NUM_REGS; r++)
            sound_regs[r] = '0;
        noise = '0;
    endfunction

    // one tick of one channel, returns 1 when a walk hit its cap
    function automatic bit advance_channel(input int c);
        bit          ovr;
        bit          run_sample;
        bit          done;
        logic [7:0]  v;
        logic [7:0]  s;
        logic [15:0] pa;
        logic [15:0] w;
        logic [SP_W-1:0] i1;
        logic [SP_W-1:0] i2;
        ovr = 1'b0;
        run_sample = 1'b1;

        // pattern walk once the note wait runs out
        note_wait[c] = note_wait[c] - 16'd1;
        if (note_wait[c] == 16'd0) begin
            done = 1'b0;
            for (int n = 0; n < MAX_COMMANDS && !done; n++) begin
                v = next_pattern_byte(c);
                pa = pat[c];
                case (v)
                    CMD_JMP:   pat[c] = song_word(pa);
                    CMD_CALL:
                    begin
                        stack_push(c, pa + 16'd2);
                        pat[c] = song_word(pa);
                    end
                    CMD_LOOP:
                    begin
                        stack_push(c, {8'h00, next_pattern_byte(c)});
                        stack_push(c, pat[c]);
                    end
                    CMD_RET:
                    begin
                        i2 = sp[c] - 2'd2;
                        i1 = sp[c] - 1'b1;
                        stack_mem[c][i2] = stack_mem[c][i2] - 16'd1;
                        if (stack_mem[c][i2][7:0] != 8'h00)
                            pat[c] = stack_mem[c][i1];
                        else
                            sp[c] = i2;
                    end
                    CMD_NOISE: noise = next_pattern_byte(c);
                    CMD_MIX:   mixer[c] = next_pattern_byte(c);
                    CMD_ORN:
                    begin
                        orn_start[c] = song_word(pa);
                        pat[c] = pa + 16'd2;
                    end
                    CMD_SMP:
                    begin
                        smp_start[c] = song_word(pa);
                        pat[c] = pa + 16'd2;
                    end
                    CMD_TRN:   trans[c] = next_pattern_byte(c);
                    CMD_POP:   pat[c] = stack_pop(c);
                    CMD_KEEP:
                    begin
                        flags[c][FL_KEEP] = 1'b1;
                        flags[c][FL_RUN] = 1'b0;
                    end
                    CMD_FREE:
                    begin
                        flags[c][FL_KEEP] = 1'b0;
                        flags[c][FL_RUN] = 1'b0;
                    end
                    CMD_SKIP:  pat[c] = pa + 16'd2;
                    CMD_NADD:  noise = (noise + next_pattern_byte(c)) & NOISE_MASK;
                    CMD_TADD:  trans[c] = trans[c] + next_pattern_byte(c);
                    CMD_PUSHT: stack_push(c, {8'h00, trans[c]});
                    CMD_POPT:
                    begin
                        w = stack_pop(c);
                        trans[c] = w[7:0];
                    end
                    default:
                    begin
                        if (v <= NOTE_MAX) begin
                            if (v != 8'h00) begin
                                note_no[c] = v + trans[c];
                                tone[c] = pitch(note_no[c]);
                                flags[c][FL_ORN] = 1'b0;
                            end
                            else begin
                                tone[c] = '0;
                            end
                            note_wait[c] = {8'h00, next_pattern_byte(c)};
                            orn_pos[c] = orn_start[c];
                            flags[c][FL_NEW] = 1'b1;
                            // sample restarts unless it is held running
                            if (!flags[c][FL_RUN]) begin
                                flags[c][FL_RUN] = flags[c][FL_KEEP];
                                smp_pos[c] = smp_start[c];
                                smp_ticks[c] = song_byte(smp_pos[c] + 16'd1);
                                smp_pos[c] = smp_pos[c] + 16'd2;
                                run_sample = 1'b0;
                            end
                            done = 1'b1;
                        end
                    end
                endcase
            end
            if (!done) begin
                ovr = 1'b1;
                note_wait[c] = 16'd1;
                run_sample = 1'b0;
            end
        end

        if (run_sample) begin
            // amplitude stream
            smp_ticks[c] = smp_ticks[c] - 8'd1;
            if (smp_ticks[c] == 8'd0) begin
                done = 1'b0;
                for (int n = 0; n < MAX_COMMANDS && !done; n++) begin
                    s = song_byte(smp_pos[c]);
                    smp_pos[c] = smp_pos[c] + 16'd1;
                    if (s == SMP_JMP) begin
                        smp_pos[c] = song_word(smp_pos[c]);
                    end
                    else if (s < SMP_AMP_LIM) begin
                        amp[c] = s;
                        smp_ticks[c] = song_byte(smp_pos[c]);
                        smp_pos[c] = smp_pos[c] + 16'd1;
                        done = 1'b1;
                    end
                    else begin
                        amp[c] = s - SMP_AMP_OFS;
                        smp_ticks[c] = 8'd1;
                        done = 1'b1;
                    end
                end
                if (!done) begin
                    ovr = 1'b1;
                    smp_ticks[c] = 8'd1;
                end
            end
            // pitch stream, not on the tick a note starts
            if (tone[c] != 16'h0000 && !flags[c][FL_NEW]) begin
                done = 1'b0;
                for (int n = 0; n < MAX_COMMANDS && !done; n++) begin
                    s = song_byte(orn_pos[c]);
                    orn_pos[c] = orn_pos[c] + 16'd1;
                    case (s)
                        ORN_JMP:     orn_pos[c] = song_word(orn_pos[c]);
                        ORN_NOTE_ON: flags[c][FL_ORN] = 1'b1;
                        ORN_NOTE_OF: flags[c][FL_ORN] = 1'b0;
                        ORN_MIXFLIP: mixer[c] = mixer[c] ^ MIX_FLIP;
                        default:
                        begin
                            if (!flags[c][FL_ORN]) begin
                                tone[c] = tone[c] + {{8{s[7]}}, s};
                            end
                            else begin
                                note_no[c] = note_no[c] + s;
                                tone[c] = pitch(note_no[c]);
                            end
                            done = 1'b1;
                        end
                    endcase
                end
                if (!done)
                    ovr = 1'b1;
            end
        end

        // channel registers
        sound_regs[6] = noise;
        flags[c][FL_NEW] = 1'b0;
        sound_regs[8 + c] = (tone[c] != 16'h0000) ? amp[c] : 8'h00;
        sound_regs[2 * c] = tone[c][7:0];
        sound_regs[2 * c + 1] = tone[c][15:8];
        return ovr;
    endfunction

    // whole tick: three channels, mixer, then 14 beats from register 13 down
    function automatic void play_tick();
        bit         ovr;
        logic [9:0] mix;
        result_t    beat;
        ovr = 1'b0;
        for (int c = 0; c < 3; c++)
            if (advance_channel(c))
                ovr = 1'b1;
        mix = {mixer[2], 2'b00} | {1'b0, mixer[1], 1'b0} | {2'b00, mixer[0]};
        sound_regs[7] = mix[7:0];
        for (int r = NUM_REGS - 1; r >= 0; r--) begin
            beat.reg_index = 4'(r);
            beat.reg_value = sound_regs[r];
            beat.last      = (r == 0);
            beat.overrun   = ovr;
            reg_writes_due.push_back(beat);
        end
    endfunction

    task automatic check_beat(input result_t got);
        result_t want;
        if (reg_writes_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected beat: reg %0d value %02h last %0b overrun %0b",
                         got.reg_index, got.reg_value, got.last, got.overrun);
        end
        else begin
            want = reg_writes_due.pop_front();
            if (got.reg_index !== want.reg_index || got.reg_value !== want.reg_value ||
                got.last !== want.last || got.overrun !== want.overrun) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("beat mismatch: expected reg %0d value %02h last %0b ovr %0b, got reg %0d value %02h last %0b ovr %0b",
                             want.reg_index, want.reg_value, want.last, want.overrun,
                             got.reg_index, got.reg_value, got.last, got.overrun);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            song_base = '0;
            for (int c = 0; c < 3; c++)
                start_reg[c] = '0;
            rewind_channels();
            reg_writes_due.delete();
            mismatches = 0;
            pending <= 0;
        end
        else begin
            if (result_valid)
                check_beat(result);
            if (cfg_we) begin
                case (cfg_index)
                    CFG_SONG_BASE: song_base = cfg_data;
                    CFG_START_A:   start_reg[0] = cfg_data;
                    CFG_START_B:   start_reg[1] = cfg_data;
                    CFG_START_C:   start_reg[2] = cfg_data;
                endcase
            end
            if (start && !busy) begin
                case (item.mode)
                    MODE_LOAD:    song_mem[item.load_offset] = item.load_byte;
                    MODE_RESTART: rewind_channels();
                    MODE_TICK:    play_tick();
                    default: ;
                endcase
            end
            pending <= reg_writes_due.size();
        end
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Fills the song memory, plays a few hand-built patterns that drive every
// walk into its cap, then loads random but well-formed songs under several
// configurations and sender idling rates while the checker compares beats.
// ----------------------------------------------------------------------------
module testbench;
    import tps_pkg::*;

    localparam logic [1:0] MODE_UNUSED  = 2'd3;
    localparam int         RANDOM_ITEMS = 470;
    localparam int         CYCLE_LIMIT  = 4000000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    item_t       item = '0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = CFG_SONG_BASE;
    logic [15:0] cfg_data = '0;
    logic        result_valid;
    result_t     result;
    int          mismatches;
    int          pending;
    int          idle_pct = 0;
    int          cycle_count = 0;
    logic [7:0]  song [$];

    always #1 clk = ~clk;

    tracker_pattern_sequencer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result       (result)
    );

    register_write_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result       (result),
        .mismatches   (mismatches),
        .pending      (pending)
    );

    // watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // one item; start is left high so back-to-back items need no re-raise
    task automatic send(input logic [1:0] mode, input logic [13:0] off, input logic [7:0] b);
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < idle_pct);
        end
        start <= 1'b1;
        item <= '{mode: mode, load_offset: off, load_byte: b};
        do @(posedge clk); while (busy);
    endtask

    // wait until no beat is due and the block is idle
    task automatic settle();
        start <= 1'b0;
        do @(posedge clk); while (pending != 0 || busy);
        repeat (8) @(posedge clk);
    endtask

    task automatic program_regs(input logic [15:0] base, a, b, c);
        cfg_we <= 1'b1;
        cfg_index <= CFG_SONG_BASE;
        cfg_data <= base;
        @(posedge clk);
        cfg_index <= CFG_START_A;
        cfg_data <= a;
        @(posedge clk);
        cfg_index <= CFG_START_B;
        cfg_data <= b;
        @(posedge clk);
        cfg_index <= CFG_START_C;
        cfg_data <= c;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic add_word(input logic [15:0] w);
        song.push_back(w[7:0]);
        song.push_back(w[15:8]);
    endtask

    // note byte and its wait, now and then a zero wait
    task automatic add_note();
        song.push_back(8'($urandom_range(0, 84)));
        song.push_back(($urandom_range(39) == 0) ? 8'h00 : 8'($urandom_range(1, 3)));
    endtask

    task automatic load_song(input logic [13:0] at);
        foreach (song[i])
            send(MODE_LOAD, at + 14'(i), song[i]);
    endtask

    initial begin
        int          random_items;
        int          phase;
        int          kind;
        int          n_parts;
        logic [15:0] base;
        logic [13:0] region_off;
        logic [15:0] region;
        logic [15:0] sub_addr;
        logic [15:0] smp_addr;
        logic [15:0] orn_addr;
        logic [15:0] loop_addr;
        logic [15:0] entry [3];
        logic [7:0]  b;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // whole song memory gets a defined value
        for (int off = 0; off < SONG_BYTES; off++)
            send(MODE_LOAD, 14'(off), 8'($urandom));
        settle();

        // directed: pattern, sample and ornament walks stuck in self jumps
        program_regs(16'h0000, 16'h0100, 16'h0110, 16'h0120);
        song = '{CMD_JMP, 8'h00, 8'h01};
        load_song(14'h0100);
        song = '{CMD_KEEP, CMD_SMP, 8'h40, 8'h01, NOTE_MAX, 8'h01, CMD_JMP, 8'h14, 8'h01};
        load_song(14'h0110);
        song = '{CMD_ORN, 8'h30, 8'h01, 8'h01, 8'h02, CMD_JMP, 8'h23, 8'h01};
        load_song(14'h0120);
        song = '{ORN_JMP, 8'h30, 8'h01};
        load_song(14'h0130);
        song = '{8'h00, 8'h01, SMP_JMP, 8'h42, 8'h01};
        load_song(14'h0140);
        send(MODE_UNUSED, 14'h3fff, 8'hff);
        send(MODE_RESTART, 14'h0000, 8'h00);
        repeat (4)
            send(MODE_TICK, 14'h0000, 8'h00);

        // random songs under changing settings
        random_items = 0;
        phase = 0;
        while (random_items < RANDOM_ITEMS) begin
            settle();
            idle_pct = (phase % 3 == 0) ? 0 : (phase % 3 == 1) ? 86 : 6;
            case (phase % 4)
                0:       base = 16'h0000;
                1:       base = 16'hffff;
                2:       base = 16'hc000;
                default: base = 16'($urandom);
            endcase
            region_off = 14'($urandom_range(0, 16000));
            region = base + 16'(region_off);
            song.delete();

            // subroutine for calls
            sub_addr = region;
            add_note();
            song.push_back(CMD_POP);

            // amplitude stream looping back past its header
            smp_addr = region + 16'(song.size());
            song.push_back(8'($urandom));
            song.push_back(8'($urandom_range(1, 3)));
            n_parts = $urandom_range(1, 4);
            for (int k = 0; k < n_parts; k++) begin
                if ($urandom_range(1)) begin
                    song.push_back(8'($urandom_range(0, 29)));
                    song.push_back(8'($urandom_range(0, 3)));
                end
                else begin
                    b = 8'($urandom_range(8'h1e, 8'hff));
                    song.push_back((b == SMP_JMP) ? 8'h81 : b);
                end
            end
            song.push_back(SMP_JMP);
            add_word(smp_addr + 16'd2);

            // pitch stream
            orn_addr = region + 16'(song.size());
            n_parts = $urandom_range(1, 4);
            for (int k = 0; k < n_parts; k++) begin
                if (k == 0 || $urandom_range(2) != 0) begin
                    b = $urandom_range(1) ? 8'($urandom_range(0, 6) - 3) : 8'($urandom);
                    if (b == ORN_JMP || b == ORN_NOTE_ON || b == ORN_NOTE_OF || b == ORN_MIXFLIP)
                        b = 8'h00;
                    song.push_back(b);
                end
                else begin
                    kind = $urandom_range(2);
                    song.push_back((kind == 0) ? ORN_NOTE_ON :
                                   (kind == 1) ? ORN_NOTE_OF : ORN_MIXFLIP);
                end
            end
            song.push_back(ORN_JMP);
            add_word(orn_addr);

            // one looping pattern per channel
            for (int ch = 0; ch < 3; ch++) begin
                entry[ch] = region + 16'(song.size());
                if ($urandom_range(1))
                    song.push_back($urandom_range(1) ? CMD_KEEP : CMD_FREE);
                song.push_back(CMD_SMP);
                add_word(smp_addr);
                song.push_back(CMD_ORN);
                add_word(orn_addr);
                loop_addr = region + 16'(song.size());
                n_parts = $urandom_range(2, 5);
                for (int k = 0; k < n_parts; k++) begin
                    kind = (k == 0) ? 0 : $urandom_range(12);
                    case (kind)
                        0: add_note();
                        1:
                        begin
                            song.push_back(CMD_NOISE);
                            song.push_back(8'($urandom));
                        end
                        2:
                        begin
                            song.push_back(CMD_MIX);
                            song.push_back(8'($urandom));
                        end
                        3:
                        begin
                            song.push_back(CMD_TRN);
                            song.push_back($urandom_range(3) ? 8'($urandom_range(0, 24))
                                                             : 8'($urandom));
                        end
                        4:
                        begin
                            song.push_back(CMD_TADD);
                            song.push_back($urandom_range(3) ? 8'($urandom_range(0, 8) - 4)
                                                             : 8'($urandom));
                        end
                        5:
                        begin
                            song.push_back(CMD_NADD);
                            song.push_back(8'($urandom));
                        end
                        6:  song.push_back($urandom_range(1) ? CMD_KEEP : CMD_FREE);
                        7:
                        begin
                            song.push_back(CMD_SKIP);
                            add_word(16'($urandom));
                        end
                        8:
                        begin
                            song.push_back(CMD_CALL);
                            add_word(sub_addr);
                        end
                        9:
                        begin
                            song.push_back(CMD_LOOP);
                            song.push_back(8'($urandom_range(1, 3)));
                            add_note();
                            song.push_back(CMD_RET);
                        end
                        10:
                        begin
                            song.push_back(CMD_PUSHT);
                            add_note();
                            song.push_back(CMD_POPT);
                        end
                        // unbalanced transpose stack, wraps in time
                        11: song.push_back($urandom_range(1) ? CMD_PUSHT : CMD_POPT);
                        default:
                            song.push_back($urandom_range(1) ? 8'($urandom_range(8'h55, 8'h7f))
                                                             : 8'($urandom_range(8'h91, 8'hff)));
                    endcase
                end
                song.push_back(CMD_JMP);
                add_word(loop_addr);
            end

            // extreme start addresses now and then
            if (phase % 4 == 1)
                entry[2] = 16'hffff;
            if (phase % 4 == 2)
                entry[0] = 16'h0000;
            program_regs(base, entry[0], entry[1], entry[2]);
            load_song(region_off);
            random_items += song.size();
            send(MODE_RESTART, 14'($urandom), 8'($urandom));
            random_items++;

            repeat (40) begin
                kind = $urandom_range(99);
                if (kind < 84)
                    send(MODE_TICK, 14'($urandom), 8'($urandom));
                else if (kind < 89)
                    send(MODE_RESTART, 14'($urandom), 8'($urandom));
                else if (kind < 95)
                    send(MODE_LOAD, 14'($urandom), 8'($urandom));
                else
                    send(MODE_UNUSED, 14'($urandom), 8'($urandom));
                if (kind < 95)
                    random_items++;
            end
            phase++;
        end

        settle();
        if (mismatches == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== tracker_pattern_sequencer.f =====
sv/tps_pkg.sv
sv/tps_ram.sv
sv/tps_ctrl.sv
sv/tps_dp.sv
sv/tracker_pattern_sequencer.sv
tb/register_write_checker.sv
tb/testbench.sv
